// File: hdl/shs_pkg.sv
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

  // byte counter and limit width
  localparam int unsigned CntW = 27;

  // limit register value after reset (64 MiB)
  localparam logic [CntW-1:0] MAX_BYTES_RST = 27'd67108864;

  // padding marker byte
  localparam logic [7:0] PAD_MARK = 8'h80;

  // command from the intake side to the compression side
  typedef struct packed {
    logic            store;     // data holds a message byte
    logic            fin;       // message ends, pad and emit digest
    logic            too_long;  // message ends over the limit
    logic [7:0]      data;
    logic [CntW-1:0] count;     // message length in bytes after this item
  } shs_cmd_t;

  // round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial chaining value
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] sml_sig0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sml_sig1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: hdl/shs_front.sv
// ----------------------------------------------------------------------------
// shs_front
// Item intake: counts message bytes, checks the length limit and turns each
// item into at most one command for the compression side.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [shs_pkg::CntW-1:0] max_bytes_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [7:0]              data_byte_i,
  input  wire logic                    byte_present_i,
  input  wire logic                    last_byte_i,
  input  wire logic                    q_full_i,
  output logic                         push_o,
  output shs_pkg::shs_cmd_t            cmd_o
);
  import shs_pkg::*;

  logic [CntW-1:0] cnt_q;
  logic            over_q;
  logic            take;
  logic            set_over;
  logic            over_now;
  logic            accept;
  logic [CntW-1:0] cnt_inc;

  // classify the item against the limit
  always_comb begin
    take     = byte_present_i && !over_q && (cnt_q < max_bytes_i);
    set_over = byte_present_i && !over_q && !(cnt_q < max_bytes_i);
    over_now = over_q || set_over;
    cnt_inc  = cnt_q + CntW'(1);
    accept   = in_valid_i && in_ready_o;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = accept && (take || last_byte_i);

  // command toward the queue
  always_comb begin
    cmd_o.store    = take;
    cmd_o.fin      = last_byte_i && !over_now;
    cmd_o.too_long = last_byte_i && over_now;
    cmd_o.data     = data_byte_i;
    cmd_o.count    = take ? cnt_inc : cnt_q;
  end

  // byte count and over-limit flag, cleared at message end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      over_q <= 1'b0;
    end else if (accept) begin
      if (last_byte_i) begin
        cnt_q  <= '0;
        over_q <= 1'b0;
      end else begin
        if (take) cnt_q <= cnt_inc;
        if (set_over) over_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/shs_fifo.sv
// ----------------------------------------------------------------------------
// shs_fifo
// Small command queue between intake and compression.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  shs_pkg::shs_cmd_t      push_data_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output shs_pkg::shs_cmd_t      data_o
);
  import shs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntQW = $clog2(DEPTH + 1);

  shs_cmd_t         mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q;
  logic [PtrW-1:0]  rd_q;
  logic [CntQW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntQW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i) rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntQW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntQW'(1);
    end
  end

  // no pop from an empty queue, no push into a full one
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("pop from empty command queue");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full command queue");
  // fill level never exceeds the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntQW'(DEPTH)) else $error("command queue fill level out of range");

endmodule

`default_nettype wire

// File: hdl/shs_back.sv
// ----------------------------------------------------------------------------
// shs_back
// Compression side: packs bytes into the block window, adds padding and
// length, runs one SHA-256 round per cycle and sends out the digest words.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  shs_pkg::shs_cmd_t   cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         digest_word_o,
  output logic [2:0]          word_index_o,
  output logic                last_word_o,
  output logic                too_long_o
);
  import shs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_TOO   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [5:0]  pos_q, pos_d;        // bytes held in the current block
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  idx_q, idx_d;
  logic        mark_q, mark_d;      // 0x80 already placed
  logic        wrap_q, wrap_d;      // marker landed past byte 55, length goes next block
  logic        finblk_q, finblk_d;  // block holding the length is in flight
  logic        padact_q, padact_d;  // finishing a message
  logic        finpend_q, finpend_d;
  logic [31:0] len_q, len_d;        // low word of the bit length, sent msb first

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];

  logic        shift_en;
  logic [7:0]  shift_byte;
  logic        round_en;
  logic        load_v;
  logic        add_h;
  logic        init_h;
  logic        out_load;
  logic        slot_free;
  logic [31:0] out_word;
  logic [2:0]  out_index;
  logic        out_last;
  logic        out_too;

  logic        out_valid_q;
  logic [31:0] word_q;
  logic [2:0]  index_q;
  logic        last_q;
  logic        too_q;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;

  assign slot_free = !out_valid_q || out_ready_i;

  // round datapath
  always_comb begin
    t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + ROUND_K[rnd_q] + w_q[0];
    t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = sml_sig1(w_q[14]) + w_q[9] + sml_sig0(w_q[1]) + w_q[0];
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    rnd_d      = rnd_q;
    idx_d      = idx_q;
    mark_d     = mark_q;
    wrap_d     = wrap_q;
    finblk_d   = finblk_q;
    padact_d   = padact_q;
    finpend_d  = finpend_q;
    len_d      = len_q;
    cmd_pop_o  = 1'b0;
    shift_en   = 1'b0;
    shift_byte = cmd_i.data;
    round_en   = 1'b0;
    load_v     = 1'b0;
    add_h      = 1'b0;
    init_h     = 1'b0;
    out_load   = 1'b0;
    out_word   = h_q[idx_q];
    out_index  = idx_q;
    out_last   = (idx_q == 3'd7);
    out_too    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.fin) begin
            len_d    = {2'b00, cmd_i.count, 3'b000};
            mark_d   = 1'b0;
            wrap_d   = 1'b0;
            finblk_d = 1'b0;
          end
          if (cmd_i.too_long) begin
            state_d = S_TOO;
          end else if (cmd_i.store) begin
            shift_en = 1'b1;
            pos_d    = pos_q + 6'd1;
            if (pos_q == 6'd63) begin
              load_v    = 1'b1;
              rnd_d     = '0;
              finpend_d = cmd_i.fin;
              state_d   = S_ROUND;
            end else if (cmd_i.fin) begin
              padact_d = 1'b1;
              state_d  = S_PAD;
            end
          end else if (cmd_i.fin) begin
            padact_d = 1'b1;
            state_d  = S_PAD;
          end
        end
      end
      S_PAD: begin
        shift_en = 1'b1;
        pos_d    = pos_q + 6'd1;
        if (!mark_q) begin
          shift_byte = PAD_MARK;
          mark_d     = 1'b1;
          if (pos_q[5:3] == 3'b111) wrap_d = 1'b1;
        end else if ((pos_q[5:3] == 3'b111) && !wrap_q) begin
          // upper length word is always zero
          shift_byte = pos_q[2] ? len_q[31:24] : 8'h00;
          if (pos_q[2]) len_d = {len_q[23:0], 8'h00};
          if (pos_q == 6'd63) finblk_d = 1'b1;
        end else begin
          shift_byte = 8'h00;
        end
        if (pos_q == 6'd63) begin
          load_v  = 1'b1;
          rnd_d   = '0;
          state_d = S_ROUND;
        end
      end
      S_ROUND: begin
        round_en = 1'b1;
        rnd_d    = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = S_ADD;
      end
      S_ADD: begin
        add_h = 1'b1;
        if (padact_q && finblk_q) begin
          idx_d   = '0;
          state_d = S_OUT;
        end else if (padact_q || finpend_q) begin
          padact_d  = 1'b1;
          finpend_d = 1'b0;
          wrap_d    = 1'b0;
          state_d   = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          idx_d    = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            init_h   = 1'b1;
            padact_d = 1'b0;
            finblk_d = 1'b0;
            state_d  = S_IDLE;
          end
        end
      end
      S_TOO: begin
        out_word  = '0;
        out_index = '0;
        out_last  = 1'b1;
        out_too   = 1'b1;
        if (slot_free) begin
          out_load = 1'b1;
          init_h   = 1'b1;
          pos_d    = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      mark_q      <= 1'b0;
      wrap_q      <= 1'b0;
      finblk_q    <= 1'b0;
      padact_q    <= 1'b0;
      finpend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      rnd_q     <= rnd_d;
      idx_q     <= idx_d;
      mark_q    <= mark_d;
      wrap_q    <= wrap_d;
      finblk_q  <= finblk_d;
      padact_q  <= padact_d;
      finpend_q <= finpend_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else if (init_h) begin
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else if (add_h) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  // block window: byte shift on intake and padding, word shift with schedule during rounds
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= {w_q[i][23:0], w_q[i+1][31:24]};
      w_q[15] <= {w_q[15][23:0], shift_byte};
    end else if (round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (load_v) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (round_en) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  // length word and result payload
  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (out_load) begin
      word_q  <= out_word;
      index_q <= out_index;
      last_q  <= out_last;
      too_q   <= out_too;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign digest_word_o = word_q;
  assign word_index_o  = index_q;
  assign last_word_o   = last_q;
  assign too_long_o    = too_q;

  // the last round always hands over to the final addition
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == 6'd63) |=> state_q == S_ADD)
    else $error("round sequence did not end in the addition step");
  // digest words only go out on a block boundary
  a_out_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> pos_q == '0)
    else $error("digest output with a partial block");
  // an over-limit result is the only and final one of its run
  a_too_long_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && too_q) |-> (last_q && index_q == '0 && word_q == '0))
    else $error("malformed too_long result");

endmodule

`default_nettype wire

// File: hdl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Streaming SHA-256 over a byte message with a message length limit.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle into the block window while the compression side
//   is idle; every 64th byte starts the rounds and the chaining add, which hold the bytes.
// After the final item: the queue, then padding, rounds and the chaining add for
//   each final block (one or two), then the eight digest words go out.
// Reset: asynchronous; clears the queue and counters, loads the initial hash
//   and a limit of 67108864 bytes; no clearing pass.
`default_nettype none

module sha256_stream_hasher_top #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [shs_pkg::CntW-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [7:0]               data_byte_i,
  input  wire logic                     byte_present_i,
  input  wire logic                     last_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [31:0]                   digest_word_o,
  output logic [2:0]                    word_index_o,
  output logic                          last_word_o,
  output logic                          too_long_o
);
  import shs_pkg::*;

  logic [CntW-1:0] max_bytes_q;
  logic            q_full;
  logic            push;
  shs_cmd_t        push_cmd;
  logic            pop;
  logic            q_valid;
  shs_cmd_t        q_cmd;

  // length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_we_i) begin
      max_bytes_q <= cfg_wdata_i;
    end
  end

  shs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .max_bytes_i    (max_bytes_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .byte_present_i (byte_present_i),
    .last_byte_i    (last_byte_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  shs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_cmd)
  );

  shs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .cmd_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o),
    .too_long_o    (too_long_o)
  );

endmodule

`default_nettype wire
